FILE: sv/byte_pattern_search_top_assert.svh
// Assertion macros for the byte pattern search checker.
// Used by bps_checker; needs a clock and reset named clock and reset in scope.
`ifndef BYTE_PATTERN_SEARCH_TOP_ASSERT_SVH
`define BYTE_PATTERN_SEARCH_TOP_ASSERT_SVH

// check while out of reset
`define BPS_ASSERT_CLK(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("bps assertion failed");

// check across reset as well
`define BPS_ASSERT_ANY(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("bps assertion failed");

`endif

FILE: sv/bps_pkg.sv
// Package for the byte pattern search block: sizes, register indexes, beat types.
// No dependencies.
`timescale 1ns / 1ps
package bps_pkg;

   localparam int MAX_PATTERN = 16;
   localparam int WIN_DEPTH   = 16;
   localparam int MAX_FRAME   = 65536;
   localparam int POS_W       = $clog2(MAX_FRAME);
   localparam int LEN_W       = 5;
   localparam int FILL_W      = $clog2(MAX_PATTERN) + 1;
   localparam int CNT_W       = 16;
   localparam int TAP_W       = $clog2(WIN_DEPTH);
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 64;

   localparam logic [POS_W-1:0]     POS_MAX   = POS_W'(MAX_FRAME - 1);
   localparam logic [CNT_W-1:0]     COUNT_MAX = '1;
   localparam logic [FILL_W-1:0]    FILL_MAX  = FILL_W'(MAX_PATTERN);
   localparam logic [LEN_W-1:0]     LEN_MAX   = LEN_W'(MAX_PATTERN);

   localparam logic [CSR_IDX_W-1:0] CSR_PAT_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_LEN  = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_beat_type;

   typedef struct packed {
      logic             found;
      logic [15:0]      first_index;
      logic [CNT_W-1:0] match_count;
   } rsp_beat_type;

   typedef struct packed {
      logic [63:0]      pattern_bytes_high;
      logic [63:0]      pattern_bytes_low;
      logic [LEN_W-1:0] pattern_length;
   } pattern_cfg_type;

endpackage

FILE: sv/bps_csr.sv
// Configuration registers of the byte pattern search block.
// Depends on bps_pkg.
`timescale 1ns / 1ps
module bps_csr
   import bps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output pattern_cfg_type       cfg
);

   pattern_cfg_type cfg_ff;
   pattern_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PAT_LOW:  cfg_in.pattern_bytes_low  = csr_wdata;
            CSR_PAT_HIGH: cfg_in.pattern_bytes_high = csr_wdata;
            CSR_PAT_LEN:  cfg_in.pattern_length     = csr_wdata[LEN_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_bytes_low  <= '0;
         cfg_ff.pattern_bytes_high <= '0;
         cfg_ff.pattern_length     <= LEN_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: sv/bps_in_reg.sv
// Input register of the byte pattern search block: holds one accepted beat.
// Depends on bps_pkg.
`timescale 1ns / 1ps
module bps_in_reg
   import bps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_beat_type req_beat,
   input  logic         advance,
   output logic         hold_valid,
   output req_beat_type hold_beat
);

   logic         valid_ff;
   req_beat_type beat_ff;

   assign req_ready = !valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         valid_ff <= 1'b1;
      end else if (advance) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         beat_ff <= req_beat;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_beat  = beat_ff;

endmodule

FILE: sv/bps_match.sv
// Window, frame state and parallel pattern compare of the byte pattern search block.
// Depends on bps_pkg.
`timescale 1ns / 1ps
module bps_match
   import bps_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  pattern_cfg_type cfg,
   input  logic            advance,
   input  req_beat_type    beat,
   output rsp_beat_type    result
);

   logic [7:0]        win_ff [WIN_DEPTH];
   logic [7:0]        win_in [WIN_DEPTH];
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [15:0]       first_ff, first_in;
   logic              seen_ff, seen_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic [127:0]      pattern;
   logic [LEN_W-1:0]  used_len;
   logic [FILL_W-1:0] fill_step;
   logic [MAX_PATTERN-1:0] byte_ok;
   logic [TAP_W-1:0]  tap_idx [MAX_PATTERN];
   logic              hit;

   assign pattern = {cfg.pattern_bytes_high, cfg.pattern_bytes_low};

   always_comb begin
      used_len = cfg.pattern_length;
      if (used_len == '0) begin
         used_len = LEN_W'(1);
      end
      if (used_len > LEN_MAX) begin
         used_len = LEN_MAX;
      end
   end

   assign fill_step = (fill_ff < FILL_MAX) ? fill_ff + FILL_W'(1) : fill_ff;

   always_comb begin
      win_in[0] = beat.data_byte;
      for (int j = 1; j < WIN_DEPTH; j++) begin
         win_in[j] = win_ff[j-1];
      end
   end

   // pattern byte k lines up with window tap used_len-1-k
   always_comb begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         tap_idx[k] = TAP_W'(used_len - LEN_W'(1) - LEN_W'(k));
         byte_ok[k] = (win_in[tap_idx[k]] == pattern[8*k +: 8]) ||
                      (LEN_W'(k) >= used_len);
      end
   end

   assign hit = (&byte_ok) && (LEN_W'(fill_step) >= used_len);

   always_comb begin
      pos_in   = (pos_ff < POS_MAX) ? pos_ff + POS_W'(1) : pos_ff;
      fill_in  = hit ? '0 : fill_step;
      seen_in  = seen_ff || hit;
      first_in = first_ff;
      count_in = count_ff;
      if (hit) begin
         if (!seen_ff) begin
            first_in = 16'(pos_ff + POS_W'(1) - POS_W'(used_len));
         end
         if (count_ff < COUNT_MAX) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      result.found       = seen_in;
      result.first_index = seen_in ? first_in : '0;
      result.match_count = count_in;
   end

   // clear the frame after its last beat
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < WIN_DEPTH; j++) begin
            win_ff[j] <= '0;
         end
         pos_ff   <= '0;
         fill_ff  <= '0;
         first_ff <= '0;
         seen_ff  <= 1'b0;
         count_ff <= '0;
      end else if (advance) begin
         if (beat.last_byte) begin
            for (int j = 0; j < WIN_DEPTH; j++) begin
               win_ff[j] <= '0;
            end
            pos_ff   <= '0;
            fill_ff  <= '0;
            first_ff <= '0;
            seen_ff  <= 1'b0;
            count_ff <= '0;
         end else begin
            for (int j = 0; j < WIN_DEPTH; j++) begin
               win_ff[j] <= win_in[j];
            end
            pos_ff   <= pos_in;
            fill_ff  <= fill_in;
            first_ff <= first_in;
            seen_ff  <= seen_in;
            count_ff <= count_in;
         end
      end
   end

endmodule

FILE: sv/bps_out_reg.sv
// Result register of the byte pattern search block.
// Depends on bps_pkg.
`timescale 1ns / 1ps
module bps_out_reg
   import bps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_beat_type load_beat,
   output logic         slot_free,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_beat_type rsp_beat
);

   logic         valid_ff;
   rsp_beat_type beat_ff;

   assign slot_free = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff <= load_beat;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_beat  = beat_ff;

endmodule

FILE: sv/byte_pattern_search_top.sv
// Channel  | Ports                                  | Direction
// req      | req_valid, req_ready, req_beat         | in:  one frame byte per beat
// rsp      | rsp_valid, rsp_ready, rsp_beat         | out: one summary beat per frame
// csr      | csr_we, csr_index, csr_wdata           | in:  register writes, no wait
// One byte per clock sustained while the result register has room; a beat leaves the
// input register the cycle after it is accepted unless a full result register holds it,
// and a last-byte beat loads its frame's summary into the result register as it leaves.
// The window compare between the two registers is combinational; the frame counters update as each beat leaves.
// A last-byte beat waits in the input register only while the result register is full
// and rsp_ready is low.
// Synchronous reset clears the frame state, the pattern bytes and both valid flags, and sets the pattern length to 1.
// Top level of the byte pattern search block; depends on bps_pkg, bps_csr, bps_in_reg, bps_match and bps_out_reg.
`timescale 1ns / 1ps
module byte_pattern_search_top
   import bps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_beat_type          req_beat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_beat_type          rsp_beat,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   pattern_cfg_type cfg;
   logic            hold_valid;
   req_beat_type    hold_beat;
   logic            advance;
   logic            slot_free;
   rsp_beat_type    result;

   assign advance = hold_valid && (!hold_beat.last_byte || slot_free);

   bps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bps_in_reg u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_beat   (req_beat),
      .advance    (advance),
      .hold_valid (hold_valid),
      .hold_beat  (hold_beat)
   );

   bps_match u_match (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .advance (advance),
      .beat    (hold_beat),
      .result  (result)
   );

   bps_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && hold_beat.last_byte),
      .load_beat (result),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_beat  (rsp_beat)
   );

endmodule

FILE: sv/bps_checker.sv
// Port-level checks for the byte pattern search block, bound to its top level.
// Depends on bps_pkg and byte_pattern_search_top_assert.svh.
`timescale 1ns / 1ps
`include "byte_pattern_search_top_assert.svh"
module bps_checker
   import bps_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_beat_type rsp_beat
);

   `BPS_ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_beat))
   `BPS_ASSERT_CLK(a_index_zero, rsp_valid && !rsp_beat.found |-> rsp_beat.first_index == '0)
   `BPS_ASSERT_CLK(a_found_count, rsp_valid |-> rsp_beat.found == (rsp_beat.match_count != '0))
   `BPS_ASSERT_CLK(a_stall_cause, !req_ready |-> rsp_valid && !rsp_ready)
   `BPS_ASSERT_ANY(a_reset_idle, reset |=> !rsp_valid)

endmodule

bind byte_pattern_search_top bps_checker u_bps_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_beat  (rsp_beat)
);

FILE: verif/tb_byte_pattern_search_top.sv
// Testbench for byte_pattern_search_top: byte frames in, per-frame match summaries out,
// checked against an in-bench scan of the configured pattern. Depends on bps_pkg and the RTL.
`timescale 1ns / 1ps
module tb_byte_pattern_search_top;
   import bps_pkg::*;

   typedef logic [7:0] byte_q_t [$];

   localparam int RSP_HOLD_CYCLES = 300;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_beat_type          req_beat  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_beat_type          rsp_beat;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_PAT_LOW;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // pattern registers as the block holds them
   logic [63:0]      pat_low_q  = '0;
   logic [63:0]      pat_high_q = '0;
   logic [LEN_W-1:0] pat_len_q  = LEN_W'(1);

   // frame scan state
   logic [7:0]       recent [WIN_DEPTH];
   logic [15:0]      next_pos  = '0;
   logic [FILL_W-1:0] run_fill = '0;
   logic [15:0]      first_hit = '0;
   logic             hit_seen  = 1'b0;
   logic [CNT_W-1:0] hits      = '0;

   rsp_beat_type pending_summaries [$];

   int unsigned bytes_sent        = 0;
   int unsigned summaries_checked = 0;
   int unsigned settings_used     = 0;
   int unsigned mismatches        = 0;
   int unsigned hold_asked        = 0;
   int unsigned hold_done         = 0;
   bit          req_idle_on       = 1'b1;
   bit          rsp_idle_on       = 1'b1;

   byte_pattern_search_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_beat  (rsp_beat),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("tb_byte_pattern_search_top: FAIL");
      $finish;
   end

   function automatic int unsigned used_length();
      int unsigned len;
      len = pat_len_q;
      if (len == 0) len = 1;
      if (len > MAX_PATTERN) len = MAX_PATTERN;
      return len;
   endfunction

   function automatic void clear_scan();
      foreach (recent[i]) recent[i] = '0;
      next_pos  = '0;
      run_fill  = '0;
      first_hit = '0;
      hit_seen  = 1'b0;
      hits      = '0;
   endfunction

   function automatic void scan_byte(input logic [7:0] b, input logic is_last);
      int unsigned  len;
      logic [15:0]  cur;
      logic [127:0] pat;
      logic         match;
      rsp_beat_type summary;
      len = used_length();
      cur = next_pos;
      pat = {pat_high_q, pat_low_q};
      for (int i = WIN_DEPTH - 1; i > 0; i--) recent[i] = recent[i-1];
      recent[0] = b;
      if (run_fill < FILL_MAX) run_fill = run_fill + 1'b1;
      if (next_pos != POS_MAX) next_pos = next_pos + 1'b1;
      match = (run_fill >= len);
      for (int k = 0; k < len; k++) begin
         if (recent[len-1-k] != pat[8*k +: 8]) match = 1'b0;
      end
      if (match) begin
         if (!hit_seen) begin
            hit_seen  = 1'b1;
            first_hit = cur + 16'd1 - 16'(len);
         end
         if (hits != COUNT_MAX) hits = hits + 1'b1;
         run_fill = '0;
      end
      if (is_last) begin
         summary.found       = hit_seen;
         summary.first_index = hit_seen ? first_hit : 16'd0;
         summary.match_count = hits;
         pending_summaries.push_back(summary);
         clear_scan();
      end
   endfunction

   function automatic byte_q_t pattern_frame(input int unsigned n);
      byte_q_t      f;
      logic [127:0] pat;
      pat = {pat_high_q, pat_low_q};
      for (int k = 0; k < n; k++) f.push_back(pat[8*k +: 8]);
      return f;
   endfunction

   function automatic logic [7:0] pattern_symbol();
      logic [7:0] alphabet [4] = '{8'h00, 8'hFF, 8'h41, 8'h42};
      return ($urandom_range(9) < 7) ? alphabet[$urandom_range(3)] : 8'($urandom);
   endfunction

   function automatic logic [63:0] random_word();
      logic [63:0] w;
      for (int k = 0; k < 8; k++) w[8*k +: 8] = pattern_symbol();
      return w;
   endfunction

   function automatic logic [LEN_W-1:0] random_length();
      int unsigned r;
      r = $urandom_range(9);
      if (r < 8) return LEN_W'($urandom_range(1, 6));
      if (r == 8) return LEN_W'($urandom_range(7, 16));
      return ($urandom_range(1) != 0) ? LEN_W'(0) : LEN_W'($urandom_range(17, 31));
   endfunction

   function automatic byte_q_t random_frame();
      byte_q_t     f;
      byte_q_t     pat;
      int unsigned target;
      int unsigned len;
      int unsigned cut;
      len    = used_length();
      pat    = pattern_frame(len);
      target = ($urandom_range(9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 20);
      while (f.size() < target) begin
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               foreach (pat[k]) f.push_back(pat[k]);
            end
            4, 5: begin
               cut = $urandom_range(len);
               for (int k = 0; k < cut; k++) f.push_back(pat[k]);
            end
            default: begin
               f.push_back(($urandom_range(1) != 0) ? pat[$urandom_range(len - 1)]
                                                     : 8'($urandom));
            end
         endcase
      end
      return f;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic is_last);
      while (req_idle_on && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_beat.data_byte <= b;
      req_beat.last_byte <= is_last;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      scan_byte(b, is_last);
   endtask

   task automatic send_frame(input byte_q_t f);
      foreach (f[i]) send_byte(f[i], i == f.size() - 1);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_summaries.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_pattern(input logic [63:0] lo, input logic [63:0] hi,
                                  input logic [LEN_W-1:0] len);
      csr_we    <= 1'b1;
      csr_index <= CSR_PAT_LOW;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_PAT_HIGH;
      csr_wdata <= hi;
      @(posedge clock);
      csr_index <= CSR_PAT_LEN;
      csr_wdata <= CSR_DATA_W'(len);
      @(posedge clock);
      csr_we     <= 1'b0;
      pat_low_q  = lo;
      pat_high_q = hi;
      pat_len_q  = len;
      settings_used++;
   endtask

   task automatic test_reset_pattern();
      send_frame({8'hFF, 8'h00, 8'h00});
      send_frame({8'hFF});
   endtask

   task automatic test_directed_cases();
      wait_idle();
      program_pattern(64'h4141, 64'h0, LEN_W'(2));
      send_frame({8'h41, 8'h41, 8'h41, 8'h41, 8'h41});
      wait_idle();
      program_pattern(64'h42_4141, 64'h0, LEN_W'(3));
      send_frame({8'h41, 8'h41, 8'h41, 8'h42});
      wait_idle();
      program_pattern(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, LEN_W'(0));
      send_frame({8'hFF, 8'h00});
      wait_idle();
      program_pattern(64'h00FF_00FF_00FF_00FF, 64'hFF00_FF00_FF00_FF00, LEN_W'(31));
      send_frame(pattern_frame(16));
      wait_idle();
      program_pattern(64'h00FF_00FF_00FF_00FF, 64'hFF00_FF00_FF00_FF00, LEN_W'(17));
      send_frame({8'hFF, 8'h00, 8'hFF});
   endtask

   task automatic test_result_backpressure();
      wait_idle();
      program_pattern(64'h7E, 64'h0, LEN_W'(1));
      hold_asked++;
      for (int i = 0; i < 40; i++) begin
         if ($urandom_range(3) == 0) send_byte(8'($urandom), 1'b0);
         send_byte(($urandom_range(1) != 0) ? 8'h7E : 8'($urandom), 1'b1);
      end
   endtask

   task automatic test_random_frames(input int unsigned n);
      int unsigned start;
      int unsigned phase_start;
      int          phase;
      start = bytes_sent;
      phase = 0;
      while (bytes_sent - start < n) begin
         wait_idle();
         req_idle_on = (phase < 3 || phase > 4);
         rsp_idle_on = req_idle_on;
         program_pattern(random_word(), random_word(), random_length());
         phase_start = bytes_sent;
         while (bytes_sent - start < n && bytes_sent - phase_start < 40) begin
            send_frame(random_frame());
         end
         phase++;
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // result side: random stalls plus one long hold on request
   initial begin
      @(posedge clock);
      forever begin
         if (hold_asked != hold_done) begin
            hold_done++;
            for (int i = 0; i < RSP_HOLD_CYCLES; i++) begin
               rsp_ready <= 1'b0;
               @(posedge clock);
            end
         end else begin
            rsp_ready <= !(rsp_idle_on && $urandom_range(99) < 8);
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_summaries.size() == 0) begin
            $display("%0t: unexpected summary: found %0d first_index %0d match_count %0d",
                     $realtime, rsp_beat.found, rsp_beat.first_index, rsp_beat.match_count);
            mismatches++;
         end else begin
            want = pending_summaries.pop_front();
            summaries_checked++;
            if (rsp_beat.found !== want.found) begin
               $display("%0t: found expected %0d actual %0d",
                        $realtime, want.found, rsp_beat.found);
               mismatches++;
            end
            if (rsp_beat.first_index !== want.first_index) begin
               $display("%0t: first_index expected %0d actual %0d",
                        $realtime, want.first_index, rsp_beat.first_index);
               mismatches++;
            end
            if (rsp_beat.match_count !== want.match_count) begin
               $display("%0t: match_count expected %0d actual %0d",
                        $realtime, want.match_count, rsp_beat.match_count);
               mismatches++;
            end
         end
      end
   end

   initial begin
      clear_scan();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_pattern();
      test_directed_cases();
      test_result_backpressure();
      test_random_frames(400);
      wait_idle();
      repeat (8) @(posedge clock);
      $display("Sent %0d frame bytes under %0d pattern settings; compared %0d summaries.",
               bytes_sent, settings_used, summaries_checked);
      $display("Included overlaps, partial restarts, odd lengths and a long result stall.");
      if (mismatches == 0) begin
         $display("tb_byte_pattern_search_top: PASS");
      end else begin
         $display("tb_byte_pattern_search_top: FAIL");
      end
      $finish;
   end

endmodule
